[rtl/rse_pkg.sv]
// Shared constants for the postfix stack evaluator.
package rse_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int DATA_W      = 32;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int MODE_W      = 4;
	localparam int VALUE_W     = 31;
	localparam int COUNT_W     = 7;
	localparam int STATUS_W    = 2;
	localparam int CMP_W       = (SP_W > COUNT_W) ? SP_W : COUNT_W;

	// token kinds
	localparam logic [MODE_W-1:0] MODE_PUSH = 4'd0;
	localparam logic [MODE_W-1:0] MODE_ADD  = 4'd1;
	localparam logic [MODE_W-1:0] MODE_SUB  = 4'd2;
	localparam logic [MODE_W-1:0] MODE_MUL  = 4'd3;
	localparam logic [MODE_W-1:0] MODE_DIV  = 4'd4;
	localparam logic [MODE_W-1:0] MODE_NEG  = 4'd5;
	localparam logic [MODE_W-1:0] MODE_IF   = 4'd6;
	localparam logic [MODE_W-1:0] MODE_MAX  = 4'd7;
	localparam logic [MODE_W-1:0] MODE_MIN  = 4'd8;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FEW  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DIV0 = 2'd2;
	localparam logic [STATUS_W-1:0] ST_OVF  = 2'd3;

endpackage

[rtl/rse_divider.sv]
// Radix-2 restoring divider on unsigned magnitudes, one quotient bit per cycle.
module rse_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rse_pkg::DATA_W-1:0]  dividend,
	input  logic [rse_pkg::DATA_W-1:0]  divisor,
	output logic                        done,
	output logic [rse_pkg::DATA_W-1:0]  quotient
);

	localparam int DW    = rse_pkg::DATA_W;
	localparam int CNT_W = $clog2(DW + 1);

	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    quo_q;
	logic [DW-1:0]    den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DW:0]      trial;
	logic [DW:0]      diff;

	assign trial = {rem_q, quo_q[DW-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: shift in one dividend bit, subtract if it fits
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			if (!diff[DW]) begin
				rem_q <= diff[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[rtl/rpn_stack_evaluator_top.sv]
// Postfix token evaluator on a 32-bit signed operand stack held in one RAM.
//
//  channel | direction | handshake            | word carries
//  --------+-----------+----------------------+------------------------------
//  token   | in        | in_valid / in_ready  | mode, value, count, last
//  answer  | out       | out_valid / out_ready| result, status (last token only)
//
// Add/sub/mul/negate/IF/MAX/MIN fetch their operands from the top down through
// the one-read-per-cycle RAM port. Divide also waits for the bit-serial divider.
// A last word also waits while the previous answer still sits in the output
// register.
// Reset clears the stack pointer, the sticky error and the output valid flag;
// the stack RAM is not cleared, entries above the pointer are never read.
// in_ready is high only between words; out_ready low stalls only a last word.
module rpn_stack_evaluator_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [rse_pkg::MODE_W-1:0]        mode,
	input  logic [rse_pkg::VALUE_W-1:0]       value,
	input  logic [rse_pkg::COUNT_W-1:0]       count,
	input  logic                              last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [rse_pkg::DATA_W-1:0] result,
	output logic [rse_pkg::STATUS_W-1:0]      status
);

	localparam int DW     = rse_pkg::DATA_W;
	localparam int AW     = rse_pkg::ADDR_W;
	localparam int SW     = rse_pkg::SP_W;
	localparam int CW     = rse_pkg::CMP_W;

	// sequencer states, one-hot
	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_EXEC = 8'b0000_0010,
		S_RD   = 8'b0000_0100,
		S_CALC = 8'b0000_1000,
		S_DIV  = 8'b0001_0000,
		S_WB   = 8'b0010_0000,
		S_DONE = 8'b0100_0000,
		S_EMIT = 8'b1000_0000
	} state_t;

	state_t                          state_q;

	// latched token
	logic [rse_pkg::MODE_W-1:0]      mode_q;
	logic [rse_pkg::VALUE_W-1:0]     value_q;
	logic [rse_pkg::COUNT_W-1:0]     count_q;
	logic                            last_q;

	// architectural state
	logic [SW-1:0]                   sp_q;
	logic [rse_pkg::STATUS_W-1:0]    err_q;

	// operand fetch
	logic [SW-1:0]                   need_q;
	logic [SW-1:0]                   iss_q;
	logic [SW-1:0]                   got_q;
	logic [AW-1:0]                   rd_ptr_q;
	logic                            rvalid_s1;
	logic [DW-1:0]                   r0_q;
	logic [DW-1:0]                   r1_q;
	logic [DW-1:0]                   r2_q;
	logic [DW-1:0]                   best_q;
	logic [DW-1:0]                   res_q;

	// answer staging
	logic [rse_pkg::STATUS_W-1:0]    emit_st_q;
	logic                            emit_mem_q;
	logic                            out_valid_q;
	logic [DW-1:0]                   result_q;
	logic [rse_pkg::STATUS_W-1:0]    status_q;

	// stack RAM
	logic [DW-1:0]                   mem [rse_pkg::STACK_DEPTH];
	logic [DW-1:0]                   rd_data_q;
	logic                            mem_we;
	logic                            mem_re;
	logic [AW-1:0]                   mem_wa;
	logic [AW-1:0]                   mem_ra;
	logic [DW-1:0]                   mem_wd;

	// misc
	logic                            in_fire;
	logic                            out_load;
	logic                            err_ok;
	logic                            sp_full;
	logic [SW-1:0]                   sp_m1;
	logic [SW-1:0]                   wb_sp;
	logic [SW-1:0]                   got_p1;
	logic [DW-1:0]                   alu;
	logic [2*DW-1:0]                 prod;
	logic [DW-1:0]                   mag_a;
	logic [DW-1:0]                   mag_b;
	logic [DW-1:0]                   quo;
	logic [DW-1:0]                   quo_signed;
	logic [DW-1:0]                   fold;
	logic                            div_start;
	logic                            div_done;
	logic                            div_zero;
	logic                            cnt_bad;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_load  = !out_valid_q || out_ready;
	assign err_ok    = (err_q == rse_pkg::ST_OK);
	assign sp_full   = (sp_q >= SW'(rse_pkg::STACK_DEPTH));
	assign sp_m1     = sp_q - 1'b1;
	assign wb_sp     = sp_q - need_q;
	assign got_p1    = got_q + 1'b1;
	assign cnt_bad   = (count_q == '0) || (CW'(count_q) > CW'(sp_q));

	// RAM port control: one access per cycle, the sequencer keeps them apart
	always_comb begin
		mem_we = 1'b0;
		mem_wa = sp_q[AW-1:0];
		mem_wd = DW'(value_q);
		mem_re = 1'b0;
		mem_ra = sp_m1[AW-1:0];
		if (state_q == S_EXEC) begin
			mem_we = err_ok && (mode_q == rse_pkg::MODE_PUSH) && !sp_full;
		end
		if (state_q == S_WB) begin
			mem_we = 1'b1;
			mem_wa = wb_sp[AW-1:0];
			mem_wd = res_q;
		end
		if (state_q == S_RD) begin
			mem_re = (iss_q < need_q);
			mem_ra = rd_ptr_q;
		end
		if (state_q == S_DONE) begin
			mem_re = last_q && err_ok && (sp_q != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_ra];
		end
	end

	// running max/min over arriving operands
	always_comb begin
		fold = best_q;
		if (got_q == '0) begin
			fold = rd_data_q;
		end else if (mode_q == rse_pkg::MODE_MAX) begin
			if ($signed(best_q) < $signed(rd_data_q)) fold = rd_data_q;
		end else begin
			if ($signed(rd_data_q) < $signed(best_q)) fold = rd_data_q;
		end
	end

	// r0 = deepest operand, r1 next, r2 top (for IF)
	assign prod  = r0_q * r1_q;
	assign mag_a = r0_q[DW-1] ? ('0 - r0_q) : r0_q;
	assign mag_b = r1_q[DW-1] ? ('0 - r1_q) : r1_q;
	assign quo_signed = (r0_q[DW-1] ^ r1_q[DW-1]) ? ('0 - quo) : quo;
	assign div_zero  = (r1_q == '0);
	assign div_start = (state_q == S_CALC) && (mode_q == rse_pkg::MODE_DIV) && !div_zero;

	always_comb begin
		case (mode_q) inside
			rse_pkg::MODE_ADD:           alu = r0_q + r1_q;
			rse_pkg::MODE_SUB:           alu = r0_q - r1_q;
			rse_pkg::MODE_MUL:           alu = prod[DW-1:0];
			rse_pkg::MODE_NEG:           alu = '0 - r0_q;
			rse_pkg::MODE_IF:            alu = ($signed(r0_q) > 0) ? r1_q : r2_q;
			rse_pkg::MODE_MAX,
			rse_pkg::MODE_MIN:           alu = best_q;
			default:                     alu = '0;
		endcase
	end

	rse_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_a),
		.divisor  (mag_b),
		.done     (div_done),
		.quotient (quo)
	);

	// token payload, no reset
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q  <= mode;
			value_q <= value;
			count_q <= count;
			last_q  <= last;
		end
		if (state_q == S_RD && rvalid_s1) begin
			r0_q   <= rd_data_q;
			r1_q   <= r0_q;
			r2_q   <= r1_q;
			best_q <= fold;
		end
		if (state_q == S_CALC) begin
			res_q <= alu;
		end
		if (state_q == S_DIV && div_done) begin
			res_q <= quo_signed;
		end
		if (state_q == S_EMIT && out_load) begin
			result_q <= emit_mem_q ? rd_data_q : '0;
			status_q <= emit_st_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sp_q        <= '0;
			err_q       <= rse_pkg::ST_OK;
			need_q      <= '0;
			iss_q       <= '0;
			got_q       <= '0;
			rd_ptr_q    <= '0;
			rvalid_s1   <= 1'b0;
			emit_st_q   <= rse_pkg::ST_OK;
			emit_mem_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rvalid_s1 <= (state_q == S_RD) && mem_re;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) state_q <= S_EXEC;
				end
				S_EXEC: begin
					iss_q    <= '0;
					got_q    <= '0;
					rd_ptr_q <= sp_m1[AW-1:0];
					state_q  <= S_DONE;
					if (err_ok) begin
						unique case (mode_q) inside
							rse_pkg::MODE_PUSH: begin
								if (sp_full) err_q <= rse_pkg::ST_OVF;
								else         sp_q  <= sp_q + 1'b1;
							end
							rse_pkg::MODE_ADD, rse_pkg::MODE_SUB,
							rse_pkg::MODE_MUL, rse_pkg::MODE_DIV: begin
								need_q <= SW'(2);
								if (sp_q < SW'(2)) err_q   <= rse_pkg::ST_FEW;
								else               state_q <= S_RD;
							end
							rse_pkg::MODE_NEG: begin
								need_q <= SW'(1);
								if (sp_q == '0) err_q   <= rse_pkg::ST_FEW;
								else            state_q <= S_RD;
							end
							rse_pkg::MODE_IF: begin
								need_q <= SW'(3);
								if (sp_q < SW'(3)) err_q   <= rse_pkg::ST_FEW;
								else               state_q <= S_RD;
							end
							rse_pkg::MODE_MAX, rse_pkg::MODE_MIN: begin
								need_q <= SW'(count_q);
								if (cnt_bad) err_q   <= rse_pkg::ST_FEW;
								else         state_q <= S_RD;
							end
							default: ; // unused kinds do nothing
						endcase
					end
				end
				S_RD: begin
					if (mem_re) begin
						iss_q    <= iss_q + 1'b1;
						rd_ptr_q <= rd_ptr_q - 1'b1;
					end
					if (rvalid_s1) begin
						got_q <= got_p1;
						if (got_p1 == need_q) state_q <= S_CALC;
					end
				end
				S_CALC: begin
					if (mode_q == rse_pkg::MODE_DIV) begin
						if (div_zero) begin
							err_q   <= rse_pkg::ST_DIV0;
							state_q <= S_DONE;
						end else begin
							state_q <= S_DIV;
						end
					end else begin
						state_q <= S_WB;
					end
				end
				S_DIV: begin
					if (div_done) state_q <= S_WB;
				end
				S_WB: begin
					sp_q    <= wb_sp + 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!last_q) begin
						state_q <= S_IDLE;
					end else begin
						emit_mem_q <= err_ok && (sp_q != '0);
						if (!err_ok)         emit_st_q <= err_q;
						else if (sp_q == '0) emit_st_q <= rse_pkg::ST_FEW;
						else                 emit_st_q <= rse_pkg::ST_OK;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						sp_q        <= '0;
						err_q       <= rse_pkg::ST_OK;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;
	assign status    = status_q;

	// stack pointer never passes the depth
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SW'(rse_pkg::STACK_DEPTH))
		else $error("stack pointer beyond depth");

	// divider finishes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider done outside wait state");

	// no stack write once the expression has failed
	a_no_wr_err: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> err_ok)
		else $error("stack written under sticky error");

	// answer hand-off clears the expression state
	a_emit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_load) |=> (sp_q == '0 && err_ok && out_valid_q))
		else $error("expression state not cleared after answer");

endmodule
